@@ sv/hsfc_pkg.sv @@
package hsfc_pkg;

  // Direction codes carried with each transaction.
  typedef enum logic {
    OP_S2H = 1'b0,
    OP_H2S = 1'b1
  } op_t;

  localparam logic [15:0] HALF_INF   = 16'h7c00;
  localparam logic [12:0] RND_HALF   = 13'h1000;
  localparam logic [31:0] SGL_INF    = 32'h7f800000;

  // Decoded operand handed from the first to the second stage.
  typedef struct packed {
    op_t         op;
    logic        sign;
    logic [7:0]  sexp;
    logic [22:0] sfrac;
    logic [4:0]  hexp;
    logic [9:0]  hfrac;
    logic [3:0]  lz;     // leading zeros of a half fraction, 0..9 for nonzero values
  } dec_t;

  // Unrounded intermediate handed from the second to the third stage.
  typedef struct packed {
    op_t         op;
    logic        sign;
    logic        special; // result fully formed, no rounding needed
    logic [31:0] word;    // finished word when special is set
    logic [9:0]  hm;      // truncated half mantissa
    logic [4:0]  hexp;
    logic        rbit;
    logic        sticky;
  } mid_t;

  // Count leading zeros of a 10-bit half fraction.
  function automatic logic [3:0] lzc10(input logic [9:0] f);
    logic [3:0] n;
    logic       found;
    n = 4'd0;
    found = 1'b0;
    for (int i = 9; i >= 0; i--) begin
      if (!found) begin
        if (f[i]) begin
          found = 1'b1;
        end else begin
          n = n + 4'd1;
        end
      end
    end
    return n;
  endfunction

endpackage

@@ sv/half_single_float_convert_top.sv @@
// Converts between binary32 and binary16 in a three-stage pipeline: field
// decode with a leading-zero count, alignment and special-case handling,
// then rounding to nearest even for half results. One transaction enters
// per cycle while the output is not stalled; a stall on the output holds
// the whole pipeline.
module half_single_float_convert_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [0] opcode, [32:1] operand_bits, zero fill
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [31:0] result_bits
);
  import hsfc_pkg::*;

  logic  en;
  logic  v1, v2;
  dec_t  dec;
  mid_t  mid;

  // The pipeline advances whenever the last stage is free or being drained.
  assign en        = out_tready || !out_tvalid;
  assign in_tready = en;

  hsfc_decode u_dec (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(in_tvalid),
    .op(op_t'(in_tdata[0])), .bits(in_tdata[32:1]), .vld_r(v1), .dec_r(dec)
  );

  hsfc_align u_aln (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(v1),
    .dec(dec), .vld_r(v2), .mid_r(mid)
  );

  hsfc_round u_rnd (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(v2),
    .mid(mid), .vld_r(out_tvalid), .res_r(out_tdata)
  );

  // A half result never sets the upper word.
  a_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (en && v2 && mid.op == OP_S2H) |=> (out_tdata[31:16] == 16'd0))
    else $error("half result has upper bits set");

  // Stalls hold the pipeline output.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("output changed during stall");

  // Valid held in the align stage passes to the output register when the pipeline is enabled.
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    (en && v2) |=> out_tvalid)
    else $error("valid lost in pipeline");

endmodule

@@ sv/hsfc_decode.sv @@
module hsfc_decode (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  hsfc_pkg::op_t      op,
  input  logic [31:0]        bits,
  output logic               vld_r,
  output hsfc_pkg::dec_t     dec_r
);
  import hsfc_pkg::*;

  dec_t dec_nxt;

  // Split fields for both directions and count the half leading zeros.
  always_comb begin
    dec_nxt.op    = op;
    dec_nxt.sign  = (op == OP_S2H) ? bits[31] : bits[15];
    dec_nxt.sexp  = bits[30:23];
    dec_nxt.sfrac = bits[22:0];
    dec_nxt.hexp  = bits[14:10];
    dec_nxt.hfrac = bits[9:0];
    dec_nxt.lz    = lzc10(bits[9:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dec_r <= dec_nxt;
    end
  end

endmodule

@@ sv/hsfc_align.sv @@
module hsfc_align (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  hsfc_pkg::dec_t     dec,
  output logic               vld_r,
  output hsfc_pkg::mid_t     mid_r
);
  import hsfc_pkg::*;

  mid_t        mid_nxt;
  logic [23:0] m;
  logic [4:0]  sh;
  logic [36:0] ext;
  logic [36:0] shd;
  logic [9:0]  nfrac;
  logic [7:0]  ne;
  logic [22:0] pay;

  // Handle special cases and align the single mantissa for rounding.
  always_comb begin
    m     = {1'b1, dec.sfrac};
    sh    = 5'd0;
    ext   = {m, 13'd0};
    shd   = '0;
    nfrac = dec.hfrac << (dec.lz + 4'd1);
    ne    = 8'd112 - {4'd0, dec.lz};
    pay   = {13'd0, dec.sfrac[22:13]};
    mid_nxt.op      = dec.op;
    mid_nxt.sign    = dec.sign;
    mid_nxt.special = 1'b1;
    mid_nxt.word    = '0;
    mid_nxt.hm      = dec.sfrac[22:13];
    mid_nxt.hexp    = 5'd0;
    mid_nxt.rbit    = dec.sfrac[12];
    mid_nxt.sticky  = |dec.sfrac[11:0];
    if (dec.op == OP_S2H) begin
      if (dec.sexp == 8'hff) begin
        if (dec.sfrac != 23'd0 && pay == 23'd0) begin
          pay = 23'd1;
        end
        mid_nxt.word = {16'd0, dec.sign, HALF_INF[14:10], pay[9:0]};
      end else if (dec.sexp > 8'd142) begin
        mid_nxt.word = {16'd0, dec.sign, HALF_INF[14:0]};
      end else if (dec.sexp < 8'd103) begin
        mid_nxt.word = {16'd0, dec.sign, 15'd0};
      end else if (dec.sexp < 8'd113) begin
        // Half subnormal: shift right by 1..10 then round.
        mid_nxt.special = 1'b0;
        sh  = 5'(8'd113 - dec.sexp);
        shd = ext >> sh;
        mid_nxt.hm     = shd[35:26];
        mid_nxt.rbit   = shd[25];
        mid_nxt.sticky = |shd[24:0] || |(ext & ~(shd << sh));
        mid_nxt.hexp   = 5'd0;
      end else begin
        mid_nxt.special = 1'b0;
        mid_nxt.hexp    = 5'(dec.sexp - 8'd112);
      end
    end else begin
      if (dec.hexp == 5'd0) begin
        if (dec.hfrac == 10'd0) begin
          mid_nxt.word = {dec.sign, 31'd0};
        end else begin
          mid_nxt.word = {dec.sign, ne, nfrac, 13'd0};
        end
      end else if (dec.hexp == 5'h1f) begin
        mid_nxt.word = {dec.sign, 31'd0} | SGL_INF | {9'd0, dec.hfrac, 13'd0};
      end else begin
        mid_nxt.word = {dec.sign, 8'({3'd0, dec.hexp} + 8'd112), dec.hfrac, 13'd0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mid_r <= mid_nxt;
    end
  end

endmodule

@@ sv/hsfc_round.sv @@
module hsfc_round (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  hsfc_pkg::mid_t     mid,
  output logic               vld_r,
  output logic [31:0]        res_r
);
  import hsfc_pkg::*;

  logic [31:0] res_nxt;
  logic        up;
  logic [15:0] mag;

  // Round to nearest even; the carry ripples naturally into the exponent.
  always_comb begin
    up  = mid.rbit && (mid.sticky || mid.hm[0]);
    mag = {1'b0, mid.hexp, mid.hm} + {15'd0, up};
    if (mag[14:10] == 5'h1f) begin
      mag = {1'b0, HALF_INF[14:0]};
    end
    if (mid.special) begin
      res_nxt = mid.word;
    end else begin
      res_nxt = {16'd0, mid.sign, mag[14:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

endmodule
